>>> rtl/core/sma_pkg.sv
`timescale 1ns / 1ps
// Package for the simple moving average block: field widths, register
// indexes, price select codes and parameter defaults. No dependencies.
package sma_pkg;

  localparam int unsigned MAX_WINDOW_DEF  = 256;
  localparam int unsigned PRICE_WIDTH_DEF = 32;

  localparam int unsigned FIELD_W    = 32;
  localparam int unsigned OUT_W      = 32;
  localparam int unsigned WIN_W      = 9;
  localparam int unsigned PSEL_W     = 2;
  localparam int unsigned CFG_ADDR_W = 4;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [WIN_W-1:0]  WINDOW_RST = WIN_W'(14);

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_WINDOW_LENGTH = 4'd0,
    REG_PRICE_SELECT  = 4'd1
  } cfg_reg_t;

  typedef enum logic [PSEL_W-1:0] {
    PSEL_OPEN  = 2'd0,
    PSEL_HIGH  = 2'd1,
    PSEL_LOW   = 2'd2,
    PSEL_CLOSE = 2'd3
  } psel_t;

endpackage

>>> rtl/core/sma_if.sv
`timescale 1ns / 1ps
// Channel interfaces for the simple moving average block: price bar input,
// average result and configuration write. Depends on sma_pkg.
interface sma_in_if import sma_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] open_price;
  logic [FIELD_W-1:0] high_price;
  logic [FIELD_W-1:0] low_price;
  logic [FIELD_W-1:0] close_price;

  modport source (output valid, open_price, high_price, low_price, close_price,
                  input ready);
  modport sink   (input valid, open_price, high_price, low_price, close_price,
                  output ready);
endinterface

interface sma_out_if import sma_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] average;
  logic             average_valid;

  modport source (output valid, average, average_valid, input ready);
  modport sink   (input valid, average, average_valid, output ready);
endinterface

interface sma_cfg_if import sma_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/core/sma_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM with one write port and a registered read.
// No dependencies.
module sma_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/core/sma_addsub.sv
`timescale 1ns / 1ps
// Shared adder and subtractor of the moving average datapath, used for the
// running sum update and for every step of the division. No dependencies.
module sma_addsub #(
  parameter int unsigned W = 40
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  input  logic         sub,
  output logic [W-1:0] res,
  output logic         carry
);

  logic [W:0] total;

  // With subtraction the carry out is high when a is not less than b.
  assign total = {1'b0, a} + {1'b0, (sub ? ~b : b)} + {{W{1'b0}}, sub};
  assign res   = total[W-1:0];
  assign carry = total[W];

endmodule

>>> rtl/core/simple_moving_average.sv
`timescale 1ns / 1ps
// Simple moving average over a stream of price bars, top level.
// Depends on sma_pkg, sma_if, sma_ram and sma_addsub.
//
// Usage: each item on in_bus is one bar with open, high, low and close
// prices in unsigned Q16.16. The field chosen by the price select register
// is stored in a circular history of the last N samples and added to a
// running sum. Every bar gives one item on out_bus. Until N samples have
// been seen the result carries average_valid low and an average of zero;
// after that it carries the truncated mean of the last N samples.
// The cfg_bus writes the window length (index 0, which also restarts the
// stream) and the price select (index 1); writes are taken only while no
// bar is in progress, and a pending write holds in_bus off.
// Order of work: an accepted bar goes through the subtract and add steps of the
// running sum update; a bar with a valid average then goes through the
// restoring divider, which produces one quotient bit per cycle on the shared
// adder, before its result is loaded; a bar seen before the window has filled
// skips the divider. in_bus is ready only while no bar is in progress, so a new
// bar is accepted only after the previous result has been loaded.
// The result waits in an output register; if the receiver stalls, the next
// bar is still accepted and processed, and is held just before its result
// is loaded until the register is free.
// Reset sets the window length to 14 and the price select to close, and
// empties the stream; the history memory itself is not cleared.
module simple_moving_average
  import sma_pkg::*;
#(
  parameter int unsigned MAX_WINDOW  = MAX_WINDOW_DEF,
  parameter int unsigned PRICE_WIDTH = PRICE_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  sma_in_if.sink    in_bus,
  sma_out_if.source out_bus,
  sma_cfg_if.sink   cfg_bus
);

  localparam int unsigned SAMPLE_W = (PRICE_WIDTH < FIELD_W) ? PRICE_WIDTH : FIELD_W;
  localparam int unsigned NMAX     = (MAX_WINDOW < 511) ? MAX_WINDOW : 511;
  localparam int unsigned SUM_W    = SAMPLE_W + $clog2(NMAX);
  localparam int unsigned ALU_W    = (SUM_W > WIN_W + 1) ? SUM_W : WIN_W + 1;
  localparam int unsigned AW       = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned CMP_W    = ((AW > WIN_W) ? AW : WIN_W) + 1;
  localparam int unsigned CNT_W    = $clog2(SUM_W + 1);
  localparam logic [WIN_W-1:0] NMAX_V = WIN_W'(NMAX);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUB,
    ST_ADD,
    ST_DIV,
    ST_PUSH
  } state_t;

  state_t              state_r;
  logic [SUM_W-1:0]    sum_r;
  logic [WIN_W-1:0]    seen_r;
  logic [AW-1:0]       pos_r;
  logic [AW-1:0]       cur_pos_r;
  logic [WIN_W-1:0]    window_r;
  logic [PSEL_W-1:0]   psel_r;
  logic [SAMPLE_W-1:0] x_r;
  logic                full_r;
  logic                res_valid_r;
  logic [SUM_W-1:0]    quo_r;
  logic [WIN_W-1:0]    rem_r;
  logic [CNT_W-1:0]    cnt_r;
  logic                out_valid_r;
  logic [OUT_W-1:0]    avg_r;
  logic                avg_valid_r;

  logic [WIN_W-1:0]    n_eff;
  logic [AW-1:0]       pos_eff;
  logic [FIELD_W-1:0]  sel_field;
  logic [SAMPLE_W-1:0] old_sample;
  logic                in_fire;
  logic                cfg_fire;
  logic [WIN_W:0]      div_shift;
  logic [CMP_W-1:0]    pos_inc;
  logic [WIN_W-1:0]    seen_inc;
  logic [ALU_W-1:0]    alu_a;
  logic [ALU_W-1:0]    alu_b;
  logic                alu_sub;
  logic [ALU_W-1:0]    alu_res;
  logic                alu_carry;

  assign in_fire  = in_bus.valid && in_bus.ready;
  assign cfg_fire = cfg_bus.valid && cfg_bus.ready;

  assign in_bus.ready          = (state_r == ST_IDLE) && !cfg_bus.valid;
  assign cfg_bus.ready         = (state_r == ST_IDLE);
  assign out_bus.valid         = out_valid_r;
  assign out_bus.average       = avg_r;
  assign out_bus.average_valid = avg_valid_r;

  always_comb begin
    if (window_r == '0) begin
      n_eff = WIN_W'(1);
    end else if (window_r > NMAX_V) begin
      n_eff = NMAX_V;
    end else begin
      n_eff = window_r;
    end
  end

  assign pos_eff  = (CMP_W'(pos_r) >= CMP_W'(n_eff)) ? '0 : pos_r;
  assign pos_inc  = CMP_W'(cur_pos_r) + CMP_W'(1);
  assign seen_inc = seen_r + WIN_W'(1);
  assign div_shift = {rem_r, quo_r[SUM_W-1]};

  always_comb begin
    case (psel_r)
      PSEL_OPEN: sel_field = in_bus.open_price;
      PSEL_HIGH: sel_field = in_bus.high_price;
      PSEL_LOW:  sel_field = in_bus.low_price;
      default:   sel_field = in_bus.close_price;
    endcase
  end

  always_comb begin
    case (state_r)
      ST_SUB: begin
        alu_a   = ALU_W'(sum_r);
        alu_b   = full_r ? ALU_W'(old_sample) : '0;
        alu_sub = 1'b1;
      end
      ST_ADD: begin
        alu_a   = ALU_W'(sum_r);
        alu_b   = ALU_W'(x_r);
        alu_sub = 1'b0;
      end
      default: begin
        alu_a   = ALU_W'(div_shift);
        alu_b   = ALU_W'(n_eff);
        alu_sub = 1'b1;
      end
    endcase
  end

  sma_addsub #(
    .W (ALU_W)
  ) u_addsub (
    .a     (alu_a),
    .b     (alu_b),
    .sub   (alu_sub),
    .res   (alu_res),
    .carry (alu_carry)
  );

  sma_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (MAX_WINDOW)
  ) u_history (
    .clk   (clk),
    .we    (state_r == ST_ADD),
    .waddr (cur_pos_r),
    .wdata (x_r),
    .re    (in_fire),
    .raddr (pos_eff),
    .rdata (old_sample)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sum_r       <= '0;
      seen_r      <= '0;
      pos_r       <= '0;
      window_r    <= WINDOW_RST;
      psel_r      <= PSEL_CLOSE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready && state_r != ST_PUSH) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            x_r       <= SAMPLE_W'(sel_field);
            cur_pos_r <= pos_eff;
            full_r    <= (seen_r >= n_eff);
            state_r   <= ST_SUB;
          end
        end
        ST_SUB: begin
          sum_r   <= alu_res[SUM_W-1:0];
          state_r <= ST_ADD;
        end
        ST_ADD: begin
          sum_r       <= alu_res[SUM_W-1:0];
          pos_r       <= (pos_inc >= CMP_W'(n_eff)) ? '0 : pos_inc[AW-1:0];
          seen_r      <= full_r ? n_eff : seen_inc;
          res_valid_r <= full_r || (seen_inc >= n_eff);
          quo_r       <= alu_res[SUM_W-1:0];
          rem_r       <= '0;
          cnt_r       <= CNT_W'(SUM_W - 1);
          state_r     <= (full_r || (seen_inc >= n_eff)) ? ST_DIV : ST_PUSH;
        end
        ST_DIV: begin
          rem_r <= alu_carry ? alu_res[WIN_W-1:0] : div_shift[WIN_W-1:0];
          quo_r <= {quo_r[SUM_W-2:0], alu_carry};
          cnt_r <= cnt_r - CNT_W'(1);
          if (cnt_r == '0) begin
            state_r <= ST_PUSH;
          end
        end
        ST_PUSH: begin
          if (!out_valid_r || out_bus.ready) begin
            out_valid_r <= 1'b1;
            avg_r       <= res_valid_r ? OUT_W'(quo_r) : '0;
            avg_valid_r <= res_valid_r;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
      if (cfg_fire) begin
        case (cfg_bus.index)
          REG_WINDOW_LENGTH: begin
            window_r <= cfg_bus.data[WIN_W-1:0];
            sum_r    <= '0;
            seen_r   <= '0;
            pos_r    <= '0;
          end
          REG_PRICE_SELECT: begin
            psel_r <= cfg_bus.data[PSEL_W-1:0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r == ST_SUB)
    else $error("accepted item did not start the sum update");

  a_seen_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    seen_r <= n_eff)
    else $error("sample count exceeds the window length");

  a_pos_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> CMP_W'(pos_r) < CMP_W'(n_eff))
    else $error("write position outside the window");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !avg_valid_r |-> avg_r == '0)
    else $error("invalid result carries a non-zero average");

  a_div_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV |-> res_valid_r)
    else $error("division started for a result that is not valid");

endmodule

>>> tb/sv/simple_moving_average_test.sv
`timescale 1ns / 1ps
// Self-checking test of simple_moving_average: random price bars, window and price select
// settings, and stalls on both channels, checked against a cycle-free average predictor.
// Depends on sma_pkg, the sma_if channel interfaces and the RTL of the block.
module simple_moving_average_test;
  import sma_pkg::*;

  localparam int unsigned LONG_HOLD    = 400;
  localparam int unsigned IDLE_LIMIT   = 4000;
  localparam int unsigned DRAIN_CYCLES = 60;
  localparam int unsigned NUM_PHASES   = 12;
  localparam logic [CFG_ADDR_W-1:0] FIRST_UNUSED_INDEX = CFG_ADDR_W'(REG_PRICE_SELECT) + 1'b1;

  typedef struct packed {
    logic [FIELD_W-1:0] open_price;
    logic [FIELD_W-1:0] high_price;
    logic [FIELD_W-1:0] low_price;
    logic [FIELD_W-1:0] close_price;
  } bar_t;

  typedef struct packed {
    logic [OUT_W-1:0] average;
    logic             average_valid;
  } average_t;

  class moving_average_board;
    logic [FIELD_W-1:0] history [MAX_WINDOW_DEF];
    logic [47:0]        running_sum;
    int unsigned        samples_seen;
    int unsigned        write_pos;
    logic [WIN_W-1:0]   window_reg;
    psel_t              price_sel;
    average_t           pending_averages [$];
    int unsigned        mismatch_count;

    function new();
      window_reg     = WINDOW_RST;
      price_sel      = PSEL_CLOSE;
      mismatch_count = 0;
      restart();
    endfunction

    function void restart();
      running_sum  = '0;
      samples_seen = 0;
      write_pos    = 0;
    endfunction

    function void write_register(logic [CFG_ADDR_W-1:0] index, logic [CFG_DATA_W-1:0] data);
      if (index == REG_WINDOW_LENGTH) begin
        window_reg = data[WIN_W-1:0];
        restart();
      end else if (index == REG_PRICE_SELECT) begin
        price_sel = psel_t'(data[PSEL_W-1:0]);
      end
    endfunction

    function void note_bar(bar_t bar);
      int unsigned        n;
      int unsigned        pos;
      logic [FIELD_W-1:0] x;
      average_t           res;
      if (window_reg == 0) n = 1;
      else if (window_reg > MAX_WINDOW_DEF) n = MAX_WINDOW_DEF;
      else n = window_reg;
      case (price_sel)
        PSEL_OPEN: x = bar.open_price;
        PSEL_HIGH: x = bar.high_price;
        PSEL_LOW:  x = bar.low_price;
        default:   x = bar.close_price;
      endcase
      pos = (write_pos >= n) ? 0 : write_pos;
      if (samples_seen >= n) begin
        running_sum  = running_sum - history[pos];
        samples_seen = n;
      end else begin
        samples_seen++;
      end
      running_sum  = running_sum + x;
      history[pos] = x;
      pos++;
      write_pos = (pos >= n) ? 0 : pos;
      if (samples_seen >= n) begin
        res.average       = OUT_W'(running_sum / n);
        res.average_valid = 1'b1;
      end else begin
        res.average       = '0;
        res.average_valid = 1'b0;
      end
      pending_averages.push_back(res);
    endfunction

    function void check_average(average_t got);
      average_t want;
      if (pending_averages.size() == 0) begin
        $display("%0t: average with no bar pending: average %h valid %b", $time,
                 got.average, got.average_valid);
        mismatch_count++;
        return;
      end
      want = pending_averages.pop_front();
      if (got.average !== want.average) begin
        $display("%0t: average expected %h actual %h", $time, want.average, got.average);
        mismatch_count++;
      end
      if (got.average_valid !== want.average_valid) begin
        $display("%0t: average_valid expected %b actual %b", $time,
                 want.average_valid, got.average_valid);
        mismatch_count++;
      end
    endfunction

    function int unsigned pending();
      return pending_averages.size();
    endfunction
  endclass

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  bit tx_stalls         = 1'b1;
  bit rx_stalls         = 1'b1;
  bit long_hold_request = 1'b0;

  int unsigned phase_window [NUM_PHASES] = '{1, 2, 7, 16, 511, 3, 64, 256, 0, 5, 33, 4};

  moving_average_board board;

  sma_in_if  in_bus ();
  sma_out_if out_bus ();
  sma_cfg_if cfg_bus ();

  simple_moving_average u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .cfg_bus (cfg_bus)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int unsigned idle_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(30, 120);
  endfunction

  function automatic int unsigned bar_gap();
    if (!tx_stalls || $urandom_range(0, 1) == 0) return 0;
    return idle_length();
  endfunction

  function automatic logic [FIELD_W-1:0] rand_price();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3:    return FIELD_W'($urandom_range(0, 255));
      4:       return ~FIELD_W'($urandom_range(0, 255));
      default: return $urandom();
    endcase
  endfunction

  task automatic offer_bar(input bar_t bar, input int unsigned gap);
    @(negedge clk);
    in_bus.valid       <= 1'b1;
    in_bus.open_price  <= bar.open_price;
    in_bus.high_price  <= bar.high_price;
    in_bus.low_price   <= bar.low_price;
    in_bus.close_price <= bar.close_price;
    do @(posedge clk); while (!(in_bus.valid && in_bus.ready));
    if (gap != 0) begin
      @(negedge clk);
      in_bus.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic wait_for_averages();
    @(negedge clk);
    in_bus.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_ADDR_W-1:0] index,
                                input logic [CFG_DATA_W-1:0] data);
    wait_for_averages();
    @(negedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= index;
    cfg_bus.data  <= data;
    do @(posedge clk); while (!(cfg_bus.valid && cfg_bus.ready));
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  // Receiver: random stalls, or a long hold-off on request while bars keep coming.
  initial begin
    int unsigned hold_left;
    int unsigned run_left;
    logic        run_ready;
    logic        next_ready;
    hold_left     = 0;
    run_left      = 0;
    run_ready     = 1'b1;
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_request) begin
        long_hold_request = 1'b0;
        hold_left         = LONG_HOLD;
      end
      if (hold_left != 0) begin
        hold_left--;
        next_ready = 1'b0;
      end else if (!rx_stalls) begin
        next_ready = 1'b1;
      end else begin
        if (run_left == 0) begin
          run_ready = ($urandom_range(0, 3) != 0);
          run_left  = run_ready ? $urandom_range(1, 20) : idle_length();
        end
        run_left--;
        next_ready = run_ready;
      end
      out_bus.ready <= next_ready;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_bus.valid && cfg_bus.ready) board.write_register(cfg_bus.index, cfg_bus.data);
      if (in_bus.valid && in_bus.ready) begin
        board.note_bar(bar_t'({in_bus.open_price, in_bus.high_price,
                               in_bus.low_price, in_bus.close_price}));
      end
      if (out_bus.valid && out_bus.ready) begin
        board.check_average(average_t'({out_bus.average, out_bus.average_valid}));
      end
    end
  end

  initial begin
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
          (cfg_bus.valid && cfg_bus.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("%0t: no item moved for %0d cycles", $time, IDLE_LIMIT);
    $display("simple_moving_average_test: FAIL");
    $finish;
  end

  initial begin
    int unsigned items;
    int unsigned window;
    board              = new();
    in_bus.valid       = 1'b0;
    in_bus.open_price  = '0;
    in_bus.high_price  = '0;
    in_bus.low_price   = '0;
    in_bus.close_price = '0;
    cfg_bus.valid      = 1'b0;
    cfg_bus.index      = '0;
    cfg_bus.data       = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: a window of fourteen on the close, so none of these is valid yet.
    offer_bar('{32'h0001_0000, 32'h0002_0000, 32'h0000_8000, 32'h0001_8000}, bar_gap());
    offer_bar('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, bar_gap());
    offer_bar('0, bar_gap());

    // A zero window behaves as a window of one; each price select in turn.
    write_register(REG_WINDOW_LENGTH, '0);
    write_register(REG_PRICE_SELECT, CFG_DATA_W'(PSEL_OPEN));
    offer_bar('{32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, bar_gap());
    offer_bar('{32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000}, bar_gap());
    write_register(REG_PRICE_SELECT, CFG_DATA_W'(PSEL_HIGH));
    offer_bar('{32'h0000_0000, 32'hA5A5_5A5A, 32'h0000_0000, 32'h0000_0000}, bar_gap());
    write_register(REG_PRICE_SELECT, CFG_DATA_W'(PSEL_LOW));
    offer_bar('{32'h0000_0000, 32'h0000_0000, 32'h5A5A_A5A5, 32'h0000_0000}, bar_gap());
    write_register(REG_PRICE_SELECT, CFG_DATA_W'(PSEL_CLOSE));
    offer_bar('{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h8000_0001}, bar_gap());

    // Upper data bits are dropped; full-scale prices carry the sum past 32 bits.
    write_register(REG_WINDOW_LENGTH, 16'hFE02);
    repeat (3) offer_bar('1, bar_gap());

    // Switching the price select keeps the samples already in the window.
    write_register(REG_PRICE_SELECT, {14'h3FFF, PSEL_OPEN});
    offer_bar('{32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, bar_gap());
    offer_bar('{32'h0000_0003, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000}, bar_gap());

    // Writes to unused indexes must change nothing.
    write_register(FIRST_UNUSED_INDEX, '1);
    write_register('1, '0);
    offer_bar('{32'h0000_0005, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000}, bar_gap());

    for (int p = 0; p < NUM_PHASES; p++) begin
      tx_stalls = (p % 3 != 0);
      rx_stalls = tx_stalls;
      window    = phase_window[p];
      items     = (window >= 200) ? 300 : 85;
      write_register(REG_WINDOW_LENGTH, {7'($urandom), WIN_W'(window)});
      write_register(REG_PRICE_SELECT, {14'($urandom), PSEL_W'($urandom_range(0, 3))});
      if (p == 1 || p == 7) long_hold_request = 1'b1;
      for (int i = 0; i < items; i++) begin
        if (i == items / 2) begin
          write_register(REG_PRICE_SELECT, {14'($urandom), PSEL_W'($urandom_range(0, 3))});
          if (p % 4 == 2) begin
            write_register(CFG_ADDR_W'($urandom_range(FIRST_UNUSED_INDEX, 2**CFG_ADDR_W - 1)),
                           CFG_DATA_W'($urandom));
          end
        end
        offer_bar('{rand_price(), rand_price(), rand_price(), rand_price()}, bar_gap());
      end
    end

    wait_for_averages();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.mismatch_count == 0 && board.pending() == 0) begin
      $display("simple_moving_average_test: PASS");
    end else begin
      $display("simple_moving_average_test: FAIL");
    end
    $finish;
  end

endmodule
